// ----- rtl/string_to_unsigned_parser_core_assert.svh -----
// Assertion helpers shared by the parser modules.
// They expect clk and rst_n in the scope where they are used.
`ifndef STRING_TO_UNSIGNED_PARSER_CORE_ASSERT_SVH
`define STRING_TO_UNSIGNED_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SUP_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Implication checked in the next cycle.
`define SUP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/sup_pkg.sv -----
`timescale 1ns / 1ps
package sup_pkg;

  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] UP_BIAS   = 8'h37;  // 'A' - 10
  localparam logic [7:0] LOW_BIAS  = 8'h57;  // 'a' - 10

  localparam logic [5:0] BASE_RESET = 6'd10;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_HEX   = 6'd16;
  localparam logic [5:0] BASE_AUTO  = 6'd0;

  // One character after classification.
  typedef struct packed {
    logic       start;
    logic       is_space;
    logic       is_minus;
    logic       is_plus;
    logic       is_x;
    logic       dig_ok;
    logic [5:0] dig;
  } sup_item_t;

endpackage

// ----- rtl/sup_front.sv -----
`timescale 1ns / 1ps
module sup_front import sup_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  logic [7:0] char_code,
  input  logic      string_start,
  output logic      full,
  output sup_item_t head,
  output logic      head_valid,
  input  logic      head_take
);

  sup_item_t  cls;
  sup_item_t  q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       wr_en;
  logic       rd_en;

  always_comb begin
    cls          = '0;
    cls.start    = string_start;
    cls.is_space = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
    cls.is_minus = (char_code == CH_MINUS);
    cls.is_plus  = (char_code == CH_PLUS);
    cls.is_x     = (char_code == CH_LOW_X) || (char_code == CH_UP_X);
    if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      cls.dig_ok = 1'b1;
      cls.dig    = 6'(char_code - CH_ZERO);
    end else if (char_code >= CH_UP_A && char_code <= CH_UP_Z) begin
      cls.dig_ok = 1'b1;
      cls.dig    = 6'(char_code - UP_BIAS);
    end else if (char_code >= CH_LOW_A && char_code <= CH_LOW_Z) begin
      cls.dig_ok = 1'b1;
      cls.dig    = 6'(char_code - LOW_BIAS);
    end
  end

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[rd_ptr_r];
  assign wr_en      = push && !full;
  assign rd_en      = head_take && head_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// ----- rtl/sup_back.sv -----
`timescale 1ns / 1ps
module sup_back import sup_pkg::*; #(
  parameter int VALUE_BITS  = 32,
  parameter int OFFSET_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [5:0]                        number_base,
  input  sup_item_t                         item,
  input  logic                              item_valid,
  output logic                              item_take,
  input  logic                              res_full,
  output logic                              res_push,
  output logic [VALUE_BITS+OFFSET_BITS+1:0] res_data
);

  `include "string_to_unsigned_parser_core_assert.svh"

  localparam int PW = VALUE_BITS + 6;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_FIRST,
    PH_PREFIX,
    PH_DIGITS
  } phase_t;

  phase_t                 phase_r, ph;
  logic [VALUE_BITS-1:0]  acc_r, acc;
  logic [5:0]             base_r, base;
  logic                   neg_r, neg;
  logic                   ovf_r, ovf;
  logic                   dig_r, dig;
  logic [OFFSET_BITS-1:0] pos_r, pos;
  logic                   cont, adv, res;
  logic [5:0]             mul_base;
  logic [PW-1:0]          prod;
  logic [VALUE_BITS-1:0]  value;
  logic                   fire;

  assign fire      = item_valid && !res_full;
  assign item_take = fire;

  always_comb begin
    ph   = item.start ? PH_SPACE : phase_r;
    acc  = item.start ? '0 : acc_r;
    base = item.start ? number_base : base_r;
    neg  = item.start ? 1'b0 : neg_r;
    ovf  = item.start ? 1'b0 : ovf_r;
    dig  = item.start ? 1'b0 : dig_r;
    pos  = item.start ? '0 : pos_r;
    cont = (ph != PH_IDLE);
    adv  = 1'b0;
    res  = 1'b0;
    prod = '0;
    mul_base = 6'd1;

    if (cont && ph == PH_SPACE) begin
      if (item.is_space) begin
        adv  = 1'b1;
        cont = 1'b0;
      end else if (item.is_minus || item.is_plus) begin
        neg  = item.is_minus;
        ph   = PH_FIRST;
        adv  = 1'b1;
        cont = 1'b0;
      end else begin
        ph = PH_FIRST;
      end
    end

    if (cont && ph == PH_FIRST) begin
      if ((base == BASE_AUTO || base == BASE_HEX) && item.dig_ok && item.dig == 6'd0) begin
        ph   = PH_PREFIX;
        adv  = 1'b1;
        cont = 1'b0;
      end else begin
        if (base == BASE_AUTO) base = BASE_DEC;
        ph = PH_DIGITS;
      end
    end else if (cont && ph == PH_PREFIX) begin
      if (item.is_x) begin
        base = BASE_HEX;
        ph   = PH_DIGITS;
        adv  = 1'b1;
        cont = 1'b0;
      end else begin
        // The leading zero counts as a digit; the accumulator stays zero.
        base = (base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
        dig  = 1'b1;
        ph   = PH_DIGITS;
      end
    end

    if (cont) begin
      if (item.dig_ok && item.dig < base) begin
        mul_base = (base == 6'd0) ? 6'd1 : base;
        prod     = PW'(acc) * PW'(mul_base) + PW'(item.dig);
        dig      = 1'b1;
        adv      = 1'b1;
        if (ovf || prod[PW-1:VALUE_BITS] != '0) begin
          ovf = 1'b1;
        end else begin
          acc = prod[VALUE_BITS-1:0];
        end
      end else begin
        res = 1'b1;
        ph  = PH_IDLE;
      end
    end

    if (adv && pos != '1) pos = pos + 1'b1;

    if (ovf) begin
      value = '1;
    end else if (neg) begin
      value = ~acc + 1'b1;
    end else begin
      value = acc;
    end
  end

  assign res_push = fire && res;
  assign res_data = {value, ovf, dig, dig ? pos : {OFFSET_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      base_r  <= '0;
      neg_r   <= 1'b0;
      ovf_r   <= 1'b0;
      dig_r   <= 1'b0;
      pos_r   <= '0;
    end else if (fire) begin
      phase_r <= ph;
      acc_r   <= acc;
      base_r  <= base;
      neg_r   <= neg;
      ovf_r   <= ovf;
      dig_r   <= dig;
      pos_r   <= pos;
    end
  end

  `SUP_ASSERT_NEXT(a_idle_after_result, res_push, phase_r == PH_IDLE)
  `SUP_ASSERT_NEXT(a_hold_without_item, !fire, $stable(phase_r) && $stable(acc_r))
  `SUP_ASSERT_IMPLIES(a_ovf_all_ones, res_push && ovf, value == {VALUE_BITS{1'b1}})

endmodule

// ----- rtl/sup_res_q.sv -----
`timescale 1ns / 1ps
module sup_res_q #(
  parameter int DATA_W = 50
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] din,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output logic [DATA_W-1:0] dout
);

  `include "string_to_unsigned_parser_core_assert.svh"

  logic [DATA_W-1:0] q_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              wr_en;
  logic              rd_en;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = q_r[rd_ptr_r];
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  `SUP_ASSERT_IMPLIES(a_no_push_when_full, push, !full)
  `SUP_ASSERT_IMPLIES(a_count_bounded, 1'b1, cnt_r != 2'd3)
  `SUP_ASSERT_NEXT(a_full_held, full && !pop, full)

endmodule

// ----- rtl/string_to_unsigned_parser_core.sv -----
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     push / full           in_char_code, in_string_start
// result    empty / pop           out_parsed_value, out_overflowed, out_digits_seen,
//                                 out_end_offset
// config    cfg_valid / cfg_ready cfg_number_base
//
// One character is taken every cycle unless full; the back end finishes one character
// per cycle unless the result queue is full, with a single multiply-add and range check
// on the accumulator. A terminating character is registered in the classification queue;
// the back end then writes its result to the result queue, whose head drives the outputs.
// Synchronous active-low reset empties both queues and returns the parser to idle.
// Full rises only when the two-entry character queue fills because results are not popped.
module string_to_unsigned_parser_core import sup_pkg::*; #(
  parameter int VALUE_BITS  = 32,
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             in_char_code,
  input  logic                   in_string_start,
  output logic                   empty,
  input  logic                   pop,
  output logic [VALUE_BITS-1:0]  out_parsed_value,
  output logic                   out_overflowed,
  output logic                   out_digits_seen,
  output logic [OFFSET_BITS-1:0] out_end_offset,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [5:0]             cfg_number_base
);

  localparam int RES_W = VALUE_BITS + OFFSET_BITS + 2;

  logic [5:0]       number_base_r;
  sup_item_t        head;
  logic             head_valid;
  logic             head_take;
  logic             res_full;
  logic             res_push;
  logic [RES_W-1:0] res_data;
  logic [RES_W-1:0] res_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      number_base_r <= cfg_number_base;
    end
  end

  sup_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .char_code    (in_char_code),
    .string_start (in_string_start),
    .full         (full),
    .head         (head),
    .head_valid   (head_valid),
    .head_take    (head_take)
  );

  sup_back #(
    .VALUE_BITS  (VALUE_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .number_base (number_base_r),
    .item        (head),
    .item_valid  (head_valid),
    .item_take   (head_take),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_data    (res_data)
  );

  sup_res_q #(
    .DATA_W (RES_W)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_data),
    .full  (res_full),
    .empty (empty),
    .pop   (pop),
    .dout  (res_head)
  );

  assign out_parsed_value = res_head[RES_W-1 -: VALUE_BITS];
  assign out_overflowed   = res_head[OFFSET_BITS+1];
  assign out_digits_seen  = res_head[OFFSET_BITS];
  assign out_end_offset   = res_head[OFFSET_BITS-1:0];

endmodule

// ----- test/tb_string_to_unsigned_parser_core.sv -----
`timescale 1ns / 1ps
module tb_string_to_unsigned_parser_core;
  import sup_pkg::*;

  localparam int VALUE_BITS   = 32;
  localparam int OFFSET_BITS  = 16;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ROUNDS = 11;
  localparam int ROUND_CHARS  = 30;
  localparam int NOT_A_DIGIT  = 99;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [VALUE_BITS-1:0] ALL_ONES = '1;

  typedef enum logic [2:0] {ST_IDLE, ST_LEAD, ST_SIGNED, ST_ZERO, ST_DIGITS} parse_state_t;

  typedef struct packed {
    logic [7:0] code;
    logic       first;
  } char_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]  value;
    logic                   ovf;
    logic                   seen;
    logic [OFFSET_BITS-1:0] offset;
  } number_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic [7:0] in_char_code = '0;
  logic       in_string_start = 1'b0;
  logic       pop = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [5:0] cfg_number_base = '0;

  wire                   full;
  wire                   empty;
  wire                   cfg_ready;
  wire [VALUE_BITS-1:0]  out_parsed_value;
  wire                   out_overflowed;
  wire                   out_digits_seen;
  wire [OFFSET_BITS-1:0] out_end_offset;

  string_to_unsigned_parser_core #(
    .VALUE_BITS (VALUE_BITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_char_code    (in_char_code),
    .in_string_start (in_string_start),
    .empty           (empty),
    .pop             (pop),
    .out_parsed_value(out_parsed_value),
    .out_overflowed  (out_overflowed),
    .out_digits_seen (out_digits_seen),
    .out_end_offset  (out_end_offset),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_number_base (cfg_number_base)
  );

  // Shadow of the parser: register, parse state and running number.
  logic [5:0]             base_reg = BASE_RESET;
  parse_state_t           parse_state = ST_IDLE;
  logic [VALUE_BITS-1:0]  acc = '0;
  logic [5:0]             act_base = '0;
  logic                   neg = 1'b0;
  logic                   ovf = 1'b0;
  logic                   seen = 1'b0;
  logic [OFFSET_BITS-1:0] pos = '0;

  char_item_t char_backlog[$];
  number_t    expected_numbers[$];

  int queued_chars = 0;
  int chars_accepted = 0;
  int results_checked = 0;
  int base_writes = 0;
  int failures = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic void bump_pos();
    if (pos != '1) pos++;
  endfunction

  // Multiply-add with the usual cutoff test; once overflowed the value is frozen.
  function automatic void accumulate(input logic [5:0] d);
    logic [VALUE_BITS-1:0] radix;
    logic [VALUE_BITS-1:0] cutoff;
    logic [VALUE_BITS-1:0] cutlim;
    radix = (act_base != 0) ? VALUE_BITS'(act_base) : VALUE_BITS'(1);
    cutoff = ALL_ONES / radix;
    cutlim = ALL_ONES % radix;
    seen = 1'b1;
    if (ovf || acc > cutoff || (acc == cutoff && VALUE_BITS'(d) > cutlim))
      ovf = 1'b1;
    else
      acc = acc * radix + VALUE_BITS'(d);
  endfunction

  // Advances the shadow by one character; returns 1 when a number is produced.
  function automatic bit parse_char(input logic [7:0] c, input logic start,
                                    output number_t num);
    int d;
    num = '0;
    if (start) begin
      parse_state = ST_LEAD;
      acc = '0;
      act_base = base_reg;
      neg = 1'b0;
      ovf = 1'b0;
      seen = 1'b0;
      pos = '0;
    end
    if (parse_state == ST_IDLE) return 1'b0;

    if (parse_state == ST_LEAD) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        bump_pos();
        return 1'b0;
      end
      if (c == CH_MINUS || c == CH_PLUS) begin
        neg = (c == CH_MINUS);
        parse_state = ST_SIGNED;
        bump_pos();
        return 1'b0;
      end
      parse_state = ST_SIGNED;
    end

    if (parse_state == ST_SIGNED) begin
      if ((act_base == BASE_AUTO || act_base == BASE_HEX) && c == CH_ZERO) begin
        parse_state = ST_ZERO;
        bump_pos();
        return 1'b0;
      end
      if (act_base == BASE_AUTO) act_base = BASE_DEC;
      parse_state = ST_DIGITS;
    end else if (parse_state == ST_ZERO) begin
      if (c == CH_LOW_X || c == CH_UP_X) begin
        act_base = BASE_HEX;
        parse_state = ST_DIGITS;
        bump_pos();
        return 1'b0;
      end
      // The leading zero was a digit after all.
      act_base = (act_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
      accumulate(6'd0);
      parse_state = ST_DIGITS;
    end

    if (c >= CH_ZERO && c <= CH_NINE) d = int'(c) - int'(CH_ZERO);
    else if (c >= CH_UP_A && c <= CH_UP_Z) d = int'(c) - int'(UP_BIAS);
    else if (c >= CH_LOW_A && c <= CH_LOW_Z) d = int'(c) - int'(LOW_BIAS);
    else d = NOT_A_DIGIT;
    if (d != NOT_A_DIGIT && d < int'(act_base)) begin
      accumulate(6'(d));
      bump_pos();
      return 1'b0;
    end

    num.value = ovf ? ALL_ONES : (neg ? VALUE_BITS'(0) - acc : acc);
    num.ovf = ovf;
    num.seen = seen;
    num.offset = seen ? pos : '0;
    parse_state = ST_IDLE;
    return 1'b1;
  endfunction

  task automatic note_failure(input string what);
    failures++;
    if (failures <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic add_char(input logic [7:0] c, input logic first);
    char_backlog.push_back('{code: c, first: first});
    queued_chars++;
  endtask

  task automatic add_text(input string s, input bit new_string, input bit terminate);
    for (int i = 0; i < s.len(); i++) add_char(s[i], new_string && i == 0);
    if (terminate) add_char(CH_NUL, new_string && s.len() == 0);
  endtask

  // Mostly well-formed numbers with random content; the rest is noise.
  task automatic add_random_string(input logic [5:0] base);
    int form;
    int n;
    int v;
    logic [5:0] radix;
    bit opening;
    opening = 1'b1;
    form = $urandom_range(99);
    if (form < 4) begin
      repeat ($urandom_range(4, 1)) add_char(8'($urandom), 1'b0);
      return;
    end
    if (form < 12) begin
      repeat ($urandom_range(6, 1)) begin
        add_char(8'($urandom), opening);
        opening = 1'b0;
      end
      return;
    end

    repeat ($urandom_range(2)) begin
      add_char(($urandom_range(5) == 0) ? CH_SPACE : 8'(CH_TAB + $urandom_range(4)), opening);
      opening = 1'b0;
    end
    case ($urandom_range(2))
      1: begin add_char(CH_MINUS, opening); opening = 1'b0; end
      2: begin add_char(CH_PLUS, opening); opening = 1'b0; end
      default: ;
    endcase
    radix = (base > 6'd36) ? 6'd36 : base;
    if (base == BASE_AUTO || base == BASE_HEX || $urandom_range(9) == 0) begin
      case ($urandom_range(3))
        1, 2: begin
          add_char(CH_ZERO, opening);
          add_char(($urandom_range(1) != 0) ? CH_LOW_X : CH_UP_X, 1'b0);
          opening = 1'b0;
          if (base == BASE_AUTO) radix = BASE_HEX;
        end
        3: begin
          add_char(CH_ZERO, opening);
          opening = 1'b0;
          if (base == BASE_AUTO) radix = BASE_OCT;
        end
        default: ;
      endcase
    end
    if (radix == BASE_AUTO) radix = BASE_DEC;

    v = $urandom_range(9);
    n = (v == 0) ? 0 : (v < 8) ? $urandom_range(6, 1) : $urandom_range(34, 8);
    repeat (n) begin
      v = $urandom_range(int'(radix) - 1);
      if (v < 10)
        add_char(8'(CH_ZERO + v), opening);
      else
        add_char(8'((($urandom_range(1) != 0) ? UP_BIAS : LOW_BIAS) + v), opening);
      opening = 1'b0;
    end
    add_char(($urandom_range(4) < 3) ? CH_NUL : 8'($urandom), opening);
    // Characters after the result and before the next start are dropped.
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(3, 1)) add_char(8'($urandom), 1'b0);
  endtask

  // Returns on a clock edge once every character is taken and every number has come out.
  task automatic wait_idle();
    do @(posedge clk);
    while (chars_accepted != queued_chars || expected_numbers.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [5:0] value);
    cfg_valid <= 1'b1;
    cfg_number_base <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    base_reg = value;
    base_writes++;
  endtask

  // Character driver.
  always @(posedge clk) begin
    char_item_t next_char;
    number_t predicted;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        chars_accepted++;
        if (parse_char(in_char_code, in_string_start, predicted))
          expected_numbers.push_back(predicted);
        send_gap = pick_gap(gap_pct);
      end
      if (!(push && full)) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
          in_char_code <= 8'($urandom);
          in_string_start <= 1'($urandom);
        end else if (char_backlog.size() != 0) begin
          next_char = char_backlog.pop_front();
          push <= 1'b1;
          in_char_code <= next_char.code;
          in_string_start <= next_char.first;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver.
  always @(posedge clk) begin
    number_t observed;
    number_t wanted;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_checked++;
        observed = {out_parsed_value, out_overflowed, out_digits_seen, out_end_offset};
        if (expected_numbers.size() == 0) begin
          note_failure($sformatf("unexpected result value %h overflow %b digits %b offset %0d",
                                 observed.value, observed.ovf, observed.seen, observed.offset));
        end else begin
          wanted = expected_numbers.pop_front();
          if (observed.value !== wanted.value)
            note_failure($sformatf("parsed_value expected %h actual %h",
                                   wanted.value, observed.value));
          if (observed.ovf !== wanted.ovf)
            note_failure($sformatf("overflowed expected %b actual %b", wanted.ovf, observed.ovf));
          if (observed.seen !== wanted.seen)
            note_failure($sformatf("digits_seen expected %b actual %b",
                                   wanted.seen, observed.seen));
          if (observed.offset !== wanted.offset)
            note_failure($sformatf("end_offset expected %0d actual %0d",
                                   wanted.offset, observed.offset));
        end
        recv_gap = pick_gap(stall_pct);
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // One long receiver hold-off so that the parser backs up and raises full.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles with %0d numbers outstanding.",
               cycle_count, expected_numbers.size());
      $display("** string_to_unsigned_parser_core: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [5:0] round_base;
    int round_start;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Base 10 from reset. Characters before the first start flag are dropped.
    add_text("7x", 1'b0, 1'b1);
    add_text("4294967295", 1'b1, 1'b1);
    add_text("4294967296", 1'b1, 1'b1);
    add_text("-1", 1'b1, 1'b1);
    add_text("+0", 1'b1, 1'b1);
    add_char(CH_SPACE, 1'b1);
    for (int c = CH_TAB; c <= CH_CR; c++) add_char(8'(c), 1'b0);
    add_text("42", 1'b0, 1'b1);
    add_text("-", 1'b1, 1'b1);
    add_text("abc", 1'b1, 1'b1);
    add_text("12", 1'b1, 1'b0);
    add_text("34", 1'b1, 1'b1);
    add_text("99", 1'b0, 1'b0);
    add_char(8'h80, 1'b1);
    add_text("5", 1'b1, 1'b0);
    add_char(8'hFF, 1'b0);
    // This string stays open across the register write and keeps base 10.
    add_text("12", 1'b1, 1'b0);
    wait_idle();
    write_base(BASE_HEX);
    add_text("F", 1'b0, 1'b1);
    add_text("0xffffffff", 1'b1, 1'b1);
    add_text("0x100000000", 1'b1, 1'b1);
    add_text("0", 1'b1, 1'b1);
    add_text("0XaB", 1'b1, 1'b1);
    wait_idle();
    write_base(BASE_AUTO);
    add_text("017", 1'b1, 1'b1);
    add_text("08", 1'b1, 1'b1);
    add_text("0x", 1'b1, 1'b1);
    add_text("0xg", 1'b1, 1'b1);
    add_text("-0x10", 1'b1, 1'b1);
    add_text("123", 1'b1, 1'b1);
    wait_idle();
    write_base(6'd1);
    add_text("000", 1'b1, 1'b1);
    add_text("01", 1'b1, 1'b1);
    wait_idle();
    write_base(6'd63);
    add_text("Zz9", 1'b1, 1'b1);
    wait_idle();
    write_base(6'd2);
    add_text("1012", 1'b1, 1'b1);
    wait_idle();
    write_base(6'd36);
    add_text("-zZ", 1'b1, 1'b1);

    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      case (round)
        0: round_base = BASE_AUTO;
        1: round_base = BASE_HEX;
        2: round_base = BASE_DEC;
        3: round_base = 6'd2;
        4: round_base = 6'd36;
        5: round_base = BASE_OCT;
        6: round_base = 6'd1;
        7: round_base = 6'd63;
        8: round_base = 6'd37;
        default: round_base = 6'($urandom_range(63));
      endcase
      wait_idle();
      write_base(round_base);
      case ($urandom_range(2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 15;
        default: stall_pct = 40;
      endcase
      round_start = queued_chars;
      while (queued_chars - round_start < ROUND_CHARS) add_random_string(round_base);
    end

    // Short numbers back to back against a stalled receiver.
    wait_idle();
    write_base(BASE_DEC);
    gap_pct = 0;
    stall_pct = 20;
    hold_req <= 1'b1;
    repeat (60) begin
      add_char(8'(CH_ZERO + $urandom_range(9)), 1'b1);
      add_char(CH_NUL, 1'b0);
    end
    wait_idle();

    $display("Checked %0d numbers from %0d accepted characters over %0d base settings.",
             results_checked, chars_accepted, base_writes);
    $display("Included signs, prefixes, overflow, restarts and a %0d-cycle receiver stall.",
             HOLD_CYCLES);
    if (failures == 0) begin
      $display("** string_to_unsigned_parser_core: PASSED **");
    end else begin
      $display("%0d mismatches in total.", failures);
      $display("** string_to_unsigned_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
